/* rtl/isa_pkg.sv */
// Package for the auto-ranging impedance sweep controller.
// Holds the field widths, command and direction codes, frame constants and the burst type.
// No dependencies; every other file imports it.
package isa_pkg;

  localparam int ADC_BITS_DEFAULT = 10;
  localparam int TH_W             = 10;
  localparam int GAIN_W           = 4;
  localparam int FREQ_W           = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 10;
  localparam int BYTE_W           = 8;
  localparam int SLOT_W           = 3;
  localparam int FRAME_SLOTS      = 8;
  localparam int CMP_W            = 17;
  localparam int WORD_W           = 16;

  // Frame layout: tag, I low, I high, Q low, Q high, freq/gain, checksum.
  localparam logic [BYTE_W-1:0] FRAME_TAG    = 8'h66;
  localparam logic [SLOT_W-1:0] SLOT_CHECK   = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_TAIL    = 3'd7;
  localparam logic [SLOT_W-1:0] SLOT_FIRST   = 3'd0;

  // Input command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  // Result kinds.
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // Last gain step taken at the current frequency.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } isa_dir_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THRESHOLD  = 2'd0,
    REG_LOW_THRESHOLD   = 2'd1,
    REG_TOP_GAIN        = 2'd2,
    REG_START_FREQUENCY = 2'd3
  } isa_reg_t;

  // All results caused by one input item, handed from the control stage to the serializer.
  typedef struct packed {
    logic                                frame;
    logic                                done;
    logic [SLOT_W-1:0]                   last_slot;
    logic [FREQ_W-1:0]                   req_freq;
    logic [GAIN_W-1:0]                   req_gain;
    logic [FRAME_SLOTS-1:0][BYTE_W-1:0]  bytes;
  } isa_burst_t;

endpackage

/* rtl/isa_channels.sv */
// Handshake channels of the impedance sweep controller: measurement items, results, config writes.
// Each interface carries valid, ready and its payload; depends on isa_pkg.
interface isa_in_if
  import isa_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
);
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ADC_BITS-1:0] adc_offset;
  logic [ADC_BITS-1:0] adc_in_phase;
  logic [ADC_BITS-1:0] adc_quadrature;

  modport source (output valid, cmd, adc_offset, adc_in_phase, adc_quadrature, input ready);
  modport sink   (input valid, cmd, adc_offset, adc_in_phase, adc_quadrature, output ready);
endinterface

interface isa_out_if
  import isa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [FREQ_W-1:0] req_frequency;
  logic [GAIN_W-1:0] req_gain;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_last;
  logic              sweep_done;

  modport source (output valid, kind, req_frequency, req_gain, frame_byte, frame_last,
                  sweep_done, input ready);
  modport sink   (input valid, kind, req_frequency, req_gain, frame_byte, frame_last,
                  sweep_done, output ready);
endinterface

interface isa_cfg_if
  import isa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/isa_control.sv */
// Control stage: configuration registers, input register, sweep state and ranging decision.
// Builds the burst of results for each item; depends on isa_pkg and isa_channels.
module isa_control
  import isa_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  isa_in_if.sink        items,
  isa_cfg_if.sink       cfg,
  input  logic          can_load,
  output logic          load,
  output isa_burst_t    burst
);

  localparam int DW = ADC_BITS + 1;

  // Configuration registers.
  logic [TH_W-1:0]   high_threshold;
  logic [TH_W-1:0]   low_threshold;
  logic [GAIN_W-1:0] top_gain;
  logic [FREQ_W-1:0] start_frequency;

  // Input register.
  logic                in_full;
  logic                in_cmd;
  logic [ADC_BITS-1:0] in_offset;
  logic [ADC_BITS-1:0] in_i;
  logic [ADC_BITS-1:0] in_q;

  // Sweep state.
  logic              sweep_active, sweep_active_next;
  logic [FREQ_W-1:0] freq_position, freq_position_next;
  logic [GAIN_W-1:0] gain_position, gain_position_next;
  isa_dir_t          last_direction, last_direction_next;

  logic                   emit;
  logic                   advance;
  logic signed [DW-1:0]   iv, qv;
  logic [DW-1:0]          i_mag, q_mag;
  logic [CMP_W-1:0]       peak;
  logic signed [CMP_W-1:0] iv_ext, qv_ext;
  logic                   want_down, want_up;
  logic [BYTE_W-1:0]      fg_byte;
  logic [BYTE_W-1:0]      check;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_threshold  <= TH_W'(900);
      low_threshold   <= TH_W'(100);
      top_gain        <= GAIN_W'(7);
      start_frequency <= FREQ_W'(10);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_HIGH_THRESHOLD:  high_threshold  <= cfg.data[TH_W-1:0];
        REG_LOW_THRESHOLD:   low_threshold   <= cfg.data[TH_W-1:0];
        REG_TOP_GAIN:        top_gain        <= cfg.data[GAIN_W-1:0];
        REG_START_FREQUENCY: start_frequency <= cfg.data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // The input register frees when its item moves on; an item without results moves at once.
  assign advance     = in_full && (!emit || can_load);
  assign load        = advance && emit;
  assign items.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (items.valid && items.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_cmd    <= items.cmd;
      in_offset <= items.adc_offset;
      in_i      <= items.adc_in_phase;
      in_q      <= items.adc_quadrature;
    end
  end

  // Offset correction and the larger magnitude of I and Q.
  always_comb begin
    iv     = $signed({1'b0, in_i}) - $signed({1'b0, in_offset});
    qv     = $signed({1'b0, in_q}) - $signed({1'b0, in_offset});
    i_mag  = iv[DW-1] ? DW'(-iv) : DW'(iv);
    q_mag  = qv[DW-1] ? DW'(-qv) : DW'(qv);
    peak   = (q_mag > i_mag) ? CMP_W'(q_mag) : CMP_W'(i_mag);
    iv_ext = CMP_W'(iv);
    qv_ext = CMP_W'(qv);
    want_down = peak > CMP_W'(high_threshold);
    want_up   = !want_down && (peak < CMP_W'(low_threshold));
    fg_byte   = {freq_position, gain_position};
    check     = FRAME_TAG ^ iv_ext[7:0] ^ iv_ext[15:8] ^ qv_ext[7:0] ^ qv_ext[15:8] ^ fg_byte;
  end

  // Ranging decision and the burst of results it causes.
  always_comb begin
    emit                = 1'b0;
    burst               = '0;
    sweep_active_next   = sweep_active;
    freq_position_next  = freq_position;
    gain_position_next  = gain_position;
    last_direction_next = last_direction;
    if (in_cmd == CMD_START) begin
      emit                = 1'b1;
      sweep_active_next   = 1'b1;
      freq_position_next  = start_frequency;
      gain_position_next  = '0;
      last_direction_next = DIR_NONE;
      burst.req_freq      = start_frequency;
      burst.last_slot     = SLOT_FIRST;
    end else if (sweep_active) begin
      emit = 1'b1;
      if (want_up && last_direction != DIR_DOWN && gain_position < top_gain) begin
        last_direction_next = DIR_UP;
        gain_position_next  = gain_position + GAIN_W'(1);
        burst.req_freq      = freq_position;
        burst.req_gain      = gain_position + GAIN_W'(1);
        burst.last_slot     = SLOT_FIRST;
      end else if (want_down && last_direction != DIR_UP && gain_position != '0) begin
        last_direction_next = DIR_DOWN;
        gain_position_next  = gain_position - GAIN_W'(1);
        burst.req_freq      = freq_position;
        burst.req_gain      = gain_position - GAIN_W'(1);
        burst.last_slot     = SLOT_FIRST;
      end else begin
        // Settled point: frame, then either the end of the sweep or the next frequency.
        last_direction_next = DIR_NONE;
        burst.frame    = 1'b1;
        burst.bytes[0] = FRAME_TAG;
        burst.bytes[1] = iv_ext[7:0];
        burst.bytes[2] = iv_ext[15:8];
        burst.bytes[3] = qv_ext[7:0];
        burst.bytes[4] = qv_ext[15:8];
        burst.bytes[5] = fg_byte;
        burst.bytes[6] = check;
        if (freq_position == '0) begin
          sweep_active_next = 1'b0;
          burst.done        = 1'b1;
          burst.last_slot   = SLOT_CHECK;
        end else begin
          freq_position_next = freq_position - FREQ_W'(1);
          burst.req_freq     = freq_position - FREQ_W'(1);
          burst.req_gain     = gain_position;
          burst.last_slot    = SLOT_TAIL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active   <= 1'b0;
      freq_position  <= '0;
      gain_position  <= '0;
      last_direction <= DIR_NONE;
    end else if (advance) begin
      sweep_active   <= sweep_active_next;
      freq_position  <= freq_position_next;
      gain_position  <= gain_position_next;
      last_direction <= last_direction_next;
    end
  end

`ifndef SYNTHESIS
  // An idle sweep carries no direction history after an item.
  a_idle_no_dir: assert property (@(posedge clk) disable iff (rst)
    advance && !sweep_active_next |=> last_direction == DIR_NONE)
    else $error("direction kept while idle");
  // A load only happens when the serializer can take it.
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("burst loaded without room");
  // Gain only moves by one per item.
  a_gain_step: assert property (@(posedge clk) disable iff (rst)
    advance && in_cmd == CMD_MEASURE |=>
      gain_position == $past(gain_position) ||
      gain_position == $past(gain_position) + GAIN_W'(1) ||
      gain_position == $past(gain_position) - GAIN_W'(1))
    else $error("gain jumped");
`endif

endmodule

/* rtl/isa_serializer.sv */
// Result serializer: holds one burst and hands its results out one per cycle while results.ready is high.
// Depends on isa_pkg and the result channel in isa_channels.
module isa_serializer
  import isa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  isa_burst_t  burst,
  output logic        can_load,
  isa_out_if.source   results
);

  logic              busy;
  logic [SLOT_W-1:0] slot;
  isa_burst_t        held;
  logic              fire;
  logic              at_last;
  logic              frame_slot;

  assign fire     = results.valid && results.ready;
  assign at_last  = slot == held.last_slot;
  assign can_load = !busy || (fire && at_last);

  // Slot counter over the held burst.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (load) begin
      busy <= 1'b1;
      slot <= SLOT_FIRST;
    end else if (fire) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= burst;
    end
  end

  // Frame bytes occupy the first slots; a request follows or stands alone.
  always_comb begin
    frame_slot            = held.frame && (slot != SLOT_TAIL);
    results.valid         = busy;
    results.kind          = frame_slot ? KIND_FRAME : KIND_REQUEST;
    results.req_frequency = frame_slot ? '0 : held.req_freq;
    results.req_gain      = frame_slot ? '0 : held.req_gain;
    results.frame_byte    = frame_slot ? held.bytes[slot] : '0;
    results.frame_last    = frame_slot && (slot == SLOT_CHECK);
    results.sweep_done    = frame_slot && (slot == SLOT_CHECK) && held.done;
  end

`ifndef SYNTHESIS
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> slot <= held.last_slot)
    else $error("slot beyond burst");
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && slot == SLOT_FIRST)
    else $error("burst did not start at first slot");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.sweep_done |-> results.frame_last && at_last)
    else $error("sweep done not on final byte");
  a_last_frame: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_last |-> results.kind == KIND_FRAME)
    else $error("frame_last on a request");
`endif

endmodule

/* rtl/impedance_sweep_autorange.sv */
// Channel    Dir  Handshake     Payload
// items      in   valid/ready   cmd, adc_offset, adc_in_phase, adc_quadrature
// results    out  valid/ready   kind, req_frequency, req_gain, frame_byte, frame_last, sweep_done
// cfg        in   valid/ready   index, data (always ready)
//
// An item waits in the input register until its results can be loaded as one burst.
// A burst gives 1 result per cycle while results.ready is high: 1 for a request, 7 or 8 for a settled point.
// A new burst loads in the cycle its predecessor's last result is taken.
// Reset (rst, synchronous) clears the sweep state and loads the register defaults.
// Top level of the auto-ranging impedance sweep controller; depends on isa_pkg, isa_channels,
// isa_control and isa_serializer.
module impedance_sweep_autorange
  import isa_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  isa_in_if.sink    items,
  isa_out_if.source results,
  isa_cfg_if.sink   cfg
);

  logic       load;
  logic       can_load;
  isa_burst_t burst;

  // Ranging decision and sweep state.
  isa_control #(
    .ADC_BITS (ADC_BITS)
  ) u_control (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .cfg      (cfg),
    .can_load (can_load),
    .load     (load),
    .burst    (burst)
  );

  // Serial output of each burst.
  isa_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst    (burst),
    .can_load (can_load),
    .results  (results)
  );

endmodule

/* dv/impedance_sweep_autorange_tb.sv */
// Testbench for impedance_sweep_autorange: directed ranging cases, then random sweeps.
// A built-in predictor tracks sweep, gain and frequency state and checks every result item.
// Depends on isa_pkg, isa_channels and the impedance_sweep_autorange RTL.
module impedance_sweep_autorange_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isa_pkg::*;

  localparam int ADC_W        = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 40;

  // One expected result item.
  typedef struct packed {
    logic              kind;
    logic [FREQ_W-1:0] freq;
    logic [GAIN_W-1:0] gain;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } sweep_result_t;

  logic clk = 1'b0;
  logic rst;

  isa_in_if #(.ADC_BITS(ADC_W)) items_if ();
  isa_out_if                    results_if ();
  isa_cfg_if                    cfg_if ();

  impedance_sweep_autorange #(.ADC_BITS(ADC_W)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  // Predictor copy of the registers and the sweep state.
  logic [TH_W-1:0]   hi_th        = 10'd900;
  logic [TH_W-1:0]   lo_th        = 10'd100;
  logic [GAIN_W-1:0] gain_ceiling = 4'd7;
  logic [FREQ_W-1:0] first_freq   = 4'd10;
  logic              sweep_on     = 1'b0;
  logic [FREQ_W-1:0] freq_pos     = '0;
  logic [GAIN_W-1:0] gain_pos     = '0;
  isa_dir_t          last_dir     = DIR_NONE;

  sweep_result_t expected_results[$];
  int mismatch_count = 0;
  int result_count   = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("impedance_sweep_autorange: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t: result %0d %s: got %0h, expected %0h", $realtime, result_count, what,
               got, want);
  endtask

  function automatic void queue_result(input logic kind, input logic [FREQ_W-1:0] f,
                                       input logic [GAIN_W-1:0] g,
                                       input logic [BYTE_W-1:0] b,
                                       input logic last, input logic done);
    expected_results.push_back('{kind, f, g, b, last, done});
  endfunction

  // Works out the result items of one accepted item and advances the sweep state.
  task automatic predict_item(input logic cmd, input logic [ADC_W-1:0] off,
                              input logic [ADC_W-1:0] ip, input logic [ADC_W-1:0] qd);
    int          iv, qv, mi, mq, peak;
    isa_dir_t    verdict;
    logic [15:0] i16, q16;
    logic [7:0]  fb [0:6];
    if (cmd == CMD_START) begin
      sweep_on = 1'b1;
      freq_pos = first_freq;
      gain_pos = '0;
      last_dir = DIR_NONE;
      queue_result(KIND_REQUEST, freq_pos, gain_pos, '0, 1'b0, 1'b0);
      return;
    end
    if (!sweep_on) return;

    iv   = int'(ip) - int'(off);
    qv   = int'(qd) - int'(off);
    mi   = (iv < 0) ? -iv : iv;
    mq   = (qv < 0) ? -qv : qv;
    peak = (mq > mi) ? mq : mi;
    if (peak > int'(hi_th)) verdict = DIR_DOWN;
    else if (peak < int'(lo_th)) verdict = DIR_UP;
    else verdict = DIR_NONE;

    // A step against an earlier step at this frequency settles the point instead.
    if (verdict == DIR_UP && last_dir != DIR_DOWN) begin
      last_dir = DIR_UP;
      if (gain_pos < gain_ceiling) begin
        gain_pos = gain_pos + 1'b1;
        queue_result(KIND_REQUEST, freq_pos, gain_pos, '0, 1'b0, 1'b0);
        return;
      end
    end else if (verdict == DIR_DOWN && last_dir != DIR_UP) begin
      last_dir = DIR_DOWN;
      if (gain_pos > 0) begin
        gain_pos = gain_pos - 1'b1;
        queue_result(KIND_REQUEST, freq_pos, gain_pos, '0, 1'b0, 1'b0);
        return;
      end
    end

    // Settled point: frame of seven bytes, then the next lower frequency or the end of the sweep.
    i16   = 16'(iv);
    q16   = 16'(qv);
    fb[0] = FRAME_TAG;
    fb[1] = i16[7:0];
    fb[2] = i16[15:8];
    fb[3] = q16[7:0];
    fb[4] = q16[15:8];
    fb[5] = {freq_pos, gain_pos};
    fb[6] = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5];
    for (int k = 0; k < 6; k++)
      queue_result(KIND_FRAME, '0, '0, fb[k], 1'b0, 1'b0);
    queue_result(KIND_FRAME, '0, '0, fb[6], 1'b1, freq_pos == 0);
    last_dir = DIR_NONE;
    if (freq_pos == 0) begin
      sweep_on = 1'b0;
    end else begin
      freq_pos = freq_pos - 1'b1;
      queue_result(KIND_REQUEST, freq_pos, gain_pos, '0, 1'b0, 1'b0);
    end
  endtask

  // Result checker: compares each accepted result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    sweep_result_t seen, want;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      seen = '{results_if.kind, results_if.req_frequency, results_if.req_gain,
               results_if.frame_byte, results_if.frame_last, results_if.sweep_done};
      if (expected_results.size() == 0) begin
        report_mismatch("with nothing expected, kind", 16'(seen.kind), '0);
      end else begin
        want = expected_results.pop_front();
        if (seen.kind !== want.kind) report_mismatch("kind", 16'(seen.kind), 16'(want.kind));
        if (seen.freq !== want.freq)
          report_mismatch("req_frequency", 16'(seen.freq), 16'(want.freq));
        if (seen.gain !== want.gain)
          report_mismatch("req_gain", 16'(seen.gain), 16'(want.gain));
        if (seen.data !== want.data)
          report_mismatch("frame_byte", 16'(seen.data), 16'(want.data));
        if (seen.last !== want.last)
          report_mismatch("frame_last", 16'(seen.last), 16'(want.last));
        if (seen.done !== want.done)
          report_mismatch("sweep_done", 16'(seen.done), 16'(want.done));
      end
      result_count++;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      results_if.ready <= 1'b0;
      hold_len--;
    end else begin
      results_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one item after a random gap and waits until it is accepted.
  task automatic offer_item(input logic cmd, input logic [ADC_W-1:0] off,
                            input logic [ADC_W-1:0] ip, input logic [ADC_W-1:0] qd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid          <= 1'b1;
    items_if.cmd            <= cmd;
    items_if.adc_offset     <= off;
    items_if.adc_in_phase   <= ip;
    items_if.adc_quadrature <= qd;
    do @(posedge clk); while (items_if.ready !== 1'b1);
    predict_item(cmd, off, ip, qd);
  endtask

  task automatic offer_start();
    offer_item(CMD_START, ADC_W'($urandom_range(1023)), ADC_W'($urandom_range(1023)),
               ADC_W'($urandom_range(1023)));
  endtask

  // Picks samples whose larger magnitude is near a threshold, below, above or between them, or anywhere.
  task automatic make_measurement(output logic [ADC_W-1:0] off, output logic [ADC_W-1:0] ip,
                                  output logic [ADC_W-1:0] qd);
    int peak, o, big, side, other;
    bit neg;
    case ($urandom_range(5))
      0: peak = $urandom_range(1023);
      1: peak = int'(lo_th) + int'($urandom_range(4)) - 2;
      2: peak = int'(hi_th) + int'($urandom_range(4)) - 2;
      3: peak = $urandom_range(lo_th);
      4: peak = int'(hi_th) + int'($urandom_range(1023 - int'(hi_th)));
      default: peak = (hi_th >= lo_th) ? int'(lo_th) + int'($urandom_range(hi_th - lo_th))
                                       : int'($urandom_range(1023));
    endcase
    if (peak < 0) peak = 0;
    if (peak > 1023) peak = 1023;
    neg   = 1'($urandom_range(1));
    o     = neg ? peak + int'($urandom_range(1023 - peak)) : int'($urandom_range(1023 - peak));
    big   = neg ? o - peak : o + peak;
    side  = $urandom_range(peak);
    other = (o + side <= 1023 && ($urandom_range(1) == 1 || o - side < 0)) ? o + side
                                                                          : o - side;
    off = ADC_W'(o);
    if ($urandom_range(1)) begin
      ip = ADC_W'(big);
      qd = ADC_W'(other);
    end else begin
      ip = ADC_W'(other);
      qd = ADC_W'(big);
    end
  endtask

  task automatic offer_measurement();
    logic [ADC_W-1:0] off, ip, qd;
    make_measurement(off, ip, qd);
    offer_item(CMD_MEASURE, off, ip, qd);
  endtask

  // Sender pauses until every expected result item has arrived.
  task automatic pause_until_drained();
    @(negedge clk) items_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Block idle: nothing expected and an ignored item has had time to pass through.
  task automatic quiesce();
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input isa_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_HIGH_THRESHOLD:  hi_th = value;
      REG_LOW_THRESHOLD:   lo_th = value;
      REG_TOP_GAIN:        gain_ceiling = value[GAIN_W-1:0];
      REG_START_FREQUENCY: first_freq = value[FREQ_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_if.valid <= 1'b0;
  endtask

  // Four-bit registers get random upper data bits, which they must drop.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [3:0] v);
    return {6'($urandom), v};
  endfunction

  task automatic load_settings(input int hi, input int lo, input int top, input int first);
    quiesce();
    write_reg(REG_HIGH_THRESHOLD, CFG_DATA_W'(hi));
    write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'(lo));
    write_reg(REG_TOP_GAIN, with_junk(4'(top)));
    write_reg(REG_START_FREQUENCY, with_junk(4'(first)));
  endtask

  // Mostly complete sweeps with random measurements, some stray items and restarts.
  task automatic run_sweep_traffic(input int n_items);
    int   sent;
    logic noise_cmd;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        noise_cmd = 1'($urandom_range(1));
        if (noise_cmd == CMD_START || sweep_on) sent++;
        offer_item(noise_cmd, ADC_W'($urandom_range(1023)), ADC_W'($urandom_range(1023)),
                   ADC_W'($urandom_range(1023)));
      end else begin
        offer_start();
        sent++;
        while (sweep_on && sent < n_items + 30) begin
          if ($urandom_range(99) < 3) offer_start();
          else offer_measurement();
          sent++;
          if ($urandom_range(99) < 2) pause_until_drained();
        end
      end
    end
  endtask

  // Directed cases: ignored items, restart, reversal both ways, gain limits, boundaries.
  task automatic test_directed_ranging();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_item(CMD_MEASURE, 10'd0, 10'd0, 10'd0);              // idle, ignored
    quiesce();
    write_reg(REG_START_FREQUENCY, with_junk(4'd1));
    offer_item(CMD_START, 10'd0, 10'd0, 10'd0);
    offer_item(CMD_MEASURE, 10'd512, 10'd512, 10'd512);        // quiet, gain up
    offer_item(CMD_MEASURE, 10'd0, 10'd1023, 10'd0);           // loud after up: settles
    offer_item(CMD_MEASURE, 10'd1023, 10'd0, 10'd0);           // negative full scale, down
    offer_item(CMD_MEASURE, 10'd300, 10'd310, 10'd290);        // quiet after down: done
    offer_item(CMD_MEASURE, 10'd1023, 10'd1023, 10'd1023);     // sweep over, ignored
    offer_item(CMD_START, 10'd1023, 10'd1023, 10'd1023);
    offer_item(CMD_MEASURE, 10'd0, 10'd0, 10'd1023);           // loud at gain 0: settles
    offer_item(CMD_START, 10'd5, 10'd6, 10'd7);                // restart while active
    // Top gain of one: the second quiet point is held at the limit.
    quiesce();
    write_reg(REG_TOP_GAIN, with_junk(4'd1));
    offer_item(CMD_MEASURE, 10'd700, 10'd705, 10'd698);
    offer_item(CMD_MEASURE, 10'd700, 10'd699, 10'd702);
    // Top gain lowered below the current gain: loud steps down, then an in-window point settles.
    quiesce();
    write_reg(REG_TOP_GAIN, with_junk(4'd0));
    offer_item(CMD_MEASURE, 10'd1023, 10'd1023, 10'd0);
    offer_item(CMD_MEASURE, 10'd0, 10'd500, 10'd300);
    // Magnitudes exactly on the thresholds do not step.
    offer_item(CMD_START, 10'd0, 10'd0, 10'd0);
    offer_item(CMD_MEASURE, 10'd0, 10'd900, 10'd0);
    offer_item(CMD_MEASURE, 10'd100, 10'd100, 10'd0);
  endtask

  task automatic test_default_thresholds();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_settings(900, 100, 7, 2);
    run_sweep_traffic(35);
  endtask

  // Widest window: nothing ever steps.
  task automatic test_open_window();
    send_idle_pct  = 53;
    recv_stall_pct = 0;
    load_settings(1023, 0, 15, 3);
    run_sweep_traffic(35);
  endtask

  // Inverted window: almost every point wants a step; single point sweeps.
  task automatic test_inverted_window();
    send_idle_pct  = 0;
    recv_stall_pct = 53;
    load_settings(0, 1023, 15, 0);
    run_sweep_traffic(35);
  endtask

  task automatic test_long_sweep();
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    load_settings(600, 300, 3, 15);
    run_sweep_traffic(35);
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 20;
    load_settings(900, 100, 7, 2);
    hold_len = HOLD_CYCLES;
    offer_start();
    repeat (12) offer_measurement();
    quiesce();
  endtask

  initial begin
    rst                     = 1'b1;
    items_if.valid          = 1'b0;
    items_if.cmd            = CMD_START;
    items_if.adc_offset     = '0;
    items_if.adc_in_phase   = '0;
    items_if.adc_quadrature = '0;
    results_if.ready        = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.index            = REG_HIGH_THRESHOLD;
    cfg_if.data             = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed_ranging();
    test_default_thresholds();
    test_open_window();
    test_inverted_window();
    test_long_sweep();
    test_output_holdoff();
    quiesce();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("impedance_sweep_autorange: match");
    end else begin
      $display("impedance_sweep_autorange: mismatch");
    end
    $finish;
  end

endmodule
